>>> hdl/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared constants and types of the LSB-first bit packer.
// ----------------------------------------------------------------------------
package lbp_pkg;

  localparam int WORD_BITS     = 32;
  localparam int MAX_CODE_BITS = 16;
  localparam int BYTE_BITS     = 8;
  localparam int ACC_BITS      = WORD_BITS + MAX_CODE_BITS;
  localparam int COUNT_W       = 5;
  localparam int VALUE_W       = 16;
  localparam int HELD_W        = 6;
  localparam int DATA_W        = 32;

  typedef enum logic {
    CMD_APPEND = 1'b0,
    CMD_FLUSH  = 1'b1
  } pack_op_e;

  typedef struct packed {
    pack_op_e             op;
    logic [COUNT_W-1:0]   count;
    logic [VALUE_W-1:0]   value;
  } pack_cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              is_byte;
    logic              last;
  } pack_res_t;

endpackage

>>> hdl/lbp_front.sv
// ----------------------------------------------------------------------------
// lbp_front
// Accepts items, saturates and masks codes, drops empty appends and queues
// the rest for the back end.
// ----------------------------------------------------------------------------
module lbp_front import lbp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               cmd_i,
  input  logic [COUNT_W-1:0] bit_count_i,
  input  logic [VALUE_W-1:0] bit_value_i,
  input  logic               deq_i,
  output logic               cmd_valid_o,
  output pack_cmd_t          cmd_o
);

  localparam logic [COUNT_W-1:0] MaxCount = COUNT_W'(MAX_CODE_BITS);

  pack_cmd_t          mem_q [2];
  logic [1:0]         cnt_q, cnt_d;
  logic               wr_q, rd_q;
  logic [COUNT_W-1:0] count_sat;
  logic [VALUE_W-1:0] mask;
  logic               keep;
  logic               enq;
  pack_cmd_t          item;

  always_comb begin
    count_sat = (bit_count_i > MaxCount) ? MaxCount : bit_count_i;
    for (int i = 0; i < VALUE_W; i++) begin
      mask[i] = (COUNT_W'(i) < count_sat);
    end
    item.op    = cmd_i ? CMD_FLUSH : CMD_APPEND;
    item.count = count_sat;
    item.value = bit_value_i & mask;
    keep       = cmd_i || (count_sat != '0);
  end

  assign full        = (cnt_q == 2'd2);
  assign enq         = push && !full && keep;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rd_q];
  assign cnt_d       = cnt_q + {1'b0, enq} - {1'b0, deq_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (enq) begin
        wr_q <= !wr_q;
      end
      if (deq_i) begin
        rd_q <= !rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      mem_q[wr_q] <= item;
    end
  end

endmodule

>>> hdl/lbp_back.sv
// ----------------------------------------------------------------------------
// lbp_back
// Holds the accumulator, packs codes, emits words and runs byte flushes into
// a two-entry result queue.
// ----------------------------------------------------------------------------
module lbp_back import lbp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  pack_cmd_t         cmd_i,
  output logic              deq_o,
  input  logic              pop,
  output logic              empty,
  output pack_res_t         res_o
);

  localparam logic [HELD_W-1:0] WordHeld = HELD_W'(WORD_BITS);
  localparam logic [HELD_W-1:0] ByteHeld = HELD_W'(BYTE_BITS);

  typedef enum logic {
    ST_RUN,
    ST_FLUSH
  } state_e;

  state_e              st_q, st_d;
  logic [ACC_BITS-1:0] acc_q, acc_d, acc_sum;
  logic [HELD_W-1:0]   held_q, held_d, held_sum;
  logic                space;
  logic                res_we;
  pack_res_t           res_d;
  pack_res_t           omem_q [2];
  logic [1:0]          ocnt_q, ocnt_d;
  logic                owr_q, ord_q;
  logic                rd_en;
  logic                last_byte;

  assign space     = (ocnt_q != 2'd2);
  assign acc_sum   = acc_q | (ACC_BITS'(cmd_i.value) << held_q);
  assign held_sum  = held_q + HELD_W'(cmd_i.count);
  assign last_byte = (held_q <= ByteHeld);

  always_comb begin
    st_d   = st_q;
    acc_d  = acc_q;
    held_d = held_q;
    deq_o  = 1'b0;
    res_we = 1'b0;
    res_d  = '0;
    case (st_q)
      ST_RUN: begin
        if (cmd_valid_i && space) begin
          deq_o = 1'b1;
          if (cmd_i.op == CMD_FLUSH) begin
            if (held_q != '0) begin
              st_d = ST_FLUSH;
            end
          end else if (held_sum >= WordHeld) begin
            res_we       = 1'b1;
            res_d.data   = DATA_W'(acc_sum[WORD_BITS-1:0]);
            acc_d        = acc_sum >> WORD_BITS;
            held_d       = held_sum - WordHeld;
          end else begin
            acc_d  = acc_sum;
            held_d = held_sum;
          end
        end
      end
      ST_FLUSH: begin
        if (space) begin
          res_we        = 1'b1;
          res_d.data    = DATA_W'(acc_q[BYTE_BITS-1:0]);
          res_d.is_byte = 1'b1;
          res_d.last    = last_byte;
          if (last_byte) begin
            st_d   = ST_RUN;
            acc_d  = '0;
            held_d = '0;
          end else begin
            acc_d  = acc_q >> BYTE_BITS;
            held_d = held_q - ByteHeld;
          end
        end
      end
      default: begin
        st_d = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_RUN;
      acc_q  <= '0;
      held_q <= '0;
    end else begin
      st_q   <= st_d;
      acc_q  <= acc_d;
      held_q <= held_d;
    end
  end

  // result queue
  assign empty  = (ocnt_q == 2'd0);
  assign rd_en  = pop && !empty;
  assign res_o  = omem_q[ord_q];
  assign ocnt_d = ocnt_q + {1'b0, res_we} - {1'b0, rd_en};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q <= 2'd0;
      owr_q  <= 1'b0;
      ord_q  <= 1'b0;
    end else begin
      ocnt_q <= ocnt_d;
      if (res_we) begin
        owr_q <= !owr_q;
      end
      if (rd_en) begin
        ord_q <= !ord_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_we) begin
      omem_q[owr_q] <= res_d;
    end
  end

endmodule

>>> hdl/lsb_first_bit_packer.sv
// ----------------------------------------------------------------------------
// lsb_first_bit_packer
// Packs 0..16-bit codes LSB first into 32-bit little-endian words; a flush
// emits the remaining bits as bytes.
// ----------------------------------------------------------------------------
// An append is handled in the packing stage and yields at most one word;
// a two-entry command queue in front and a two-entry result queue behind let
// appends stream at one item per cycle while results are popped and no flush
// is in progress. A flush writes its bytes (up to four) in the flush state,
// one result per cycle while the result queue has space. Zero-count appends
// are dropped on entry, and a flush of an empty accumulator gives no result.
module lsb_first_bit_packer import lbp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               cmd_i,
  input  logic [COUNT_W-1:0] bit_count_i,
  input  logic [VALUE_W-1:0] bit_value_i,
  output logic               empty,
  input  logic               pop,
  output logic [DATA_W-1:0]  out_data_o,
  output logic               out_is_byte_o,
  output logic               out_last_o
);

  logic      cmd_valid;
  logic      deq;
  pack_cmd_t cmd;
  pack_res_t res;

  lbp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .cmd_i       (cmd_i),
    .bit_count_i (bit_count_i),
    .bit_value_i (bit_value_i),
    .deq_i       (deq),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  lbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .deq_o       (deq),
    .pop         (pop),
    .empty       (empty),
    .res_o       (res)
  );

  assign out_data_o    = res.data;
  assign out_is_byte_o = res.is_byte;
  assign out_last_o    = res.last;

  a_deq_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq |-> cmd_valid)
    else $error("command taken from empty queue");

  a_last_is_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_last_o) |-> out_is_byte_o)
    else $error("last marker on a word result");

  a_byte_high_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_is_byte_o) |-> (out_data_o[DATA_W-1:BYTE_BITS] == '0))
    else $error("flushed byte has high bits set");

endmodule
